>>> design/sae_pkg.sv
// Package for the stray ampersand escaper: item types, sizing constants,
// character codes and small decode helpers.
// No dependencies; used by the top level, the checker and the testbench.
package sae_pkg;

   localparam int MAX_ENTITY_LEN = 30;
   localparam int ADDR_W = (MAX_ENTITY_LEN > 1) ? $clog2(MAX_ENTITY_LEN) : 1;
   localparam int CNT_W  = ADDR_W;
   localparam int IDX_W  = (ADDR_W > 2) ? ADDR_W : 2;

   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_DQUOT = 8'h22;
   localparam logic [7:0] CH_SQUOT = 8'h27;
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_M     = 8'h6D;
   localparam logic [7:0] CH_P     = 8'h70;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       out_msg_end;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_PRE  = 5'b00010,
      S_HELD = 5'b00100,
      S_TAIL = 5'b01000,
      S_POST = 5'b10000
   } state_type;

   // Bytes that end an entity lookahead without a semicolon.
   function automatic logic is_breaking(input logic [7:0] b);
      return (b == CH_AMP) || (b == CH_SPACE) || (b == CH_LT) || (b == CH_GT) ||
             (b == CH_CR) || (b == CH_LF) || (b == CH_DQUOT) || (b == CH_SQUOT) ||
             (b == CH_NUL);
   endfunction

   // Characters of the inserted "amp;" sequence.
   function automatic logic [7:0] amp_char(input logic [1:0] pos);
      logic [7:0] c;
      unique case (pos)
         2'd0: c = CH_A;
         2'd1: c = CH_M;
         2'd2: c = CH_P;
         2'd3: c = CH_SEMI;
      endcase
      return c;
   endfunction

endpackage

>>> design/sae_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sae_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 30
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/stray_ampersand_escaper.sv
// Top level of the stray ampersand escaper: control sequencer and output register.
// Depends on sae_pkg and sae_ram (held-byte store).
//
// Passes a message through byte by byte and repairs ampersands that do not open a
// well-formed entity by inserting "amp;" after them. After an ampersand, following
// bytes are parked in a small held-byte RAM; a semicolon within MAX_ENTITY_LEN bytes
// releases them untouched, while a breaking byte (& space < > CR LF " ' NUL), the
// length limit or the end of the message releases them behind "amp;". Rate: an item
// that yields one byte, or none (a byte parked in the lookahead), is taken every
// cycle the output side is not stalled. An item that closes a lookahead is accepted
// and then releases its result bytes in order: "amp;" for a repair, the held bytes,
// the item's own byte and "amp;" once more for an ampersand ending the message.
// Held bytes come out of the single read port of the RAM one per cycle while the
// output is not stalled, and the input is stalled until the whole release has gone.
module stray_ampersand_escaper (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  sae_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output sae_pkg::rsp_type rsp_data
);

   sae_pkg::state_type state_ff, state_in;
   logic [sae_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [sae_pkg::CNT_W-1:0] count_ff, count_in;
   logic pending_ff, pending_in;

   // Job captured when an item releases the lookahead.
   logic [7:0] tail_ff, tail_in;
   logic post_ff, post_in;
   logic msg_last_ff, msg_last_in;

   // Output register.
   logic rsp_valid_ff, rsp_valid_in;
   sae_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic can_load, accept, closes, last_held, is_amp, is_semi, is_brk;
   logic wr_en;
   logic [7:0] rd_data;

   assign can_load  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != sae_pkg::S_IDLE) || !can_load;
   assign accept    = req_valid && !req_stall;

   assign is_amp  = (req_data.in_byte == sae_pkg::CH_AMP);
   assign is_semi = (req_data.in_byte == sae_pkg::CH_SEMI);
   assign is_brk  = sae_pkg::is_breaking(req_data.in_byte);
   // this ordinary byte would fill the lookahead to its limit
   assign closes  = ((sae_pkg::CNT_W+1)'(count_ff) + (sae_pkg::CNT_W+1)'(1)) >=
                    (sae_pkg::CNT_W+1)'(sae_pkg::MAX_ENTITY_LEN);
   assign last_held = (idx_ff == (sae_pkg::IDX_W'(count_ff) - sae_pkg::IDX_W'(1)));

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      pending_in   = pending_ff;
      tail_in      = tail_ff;
      post_in      = post_ff;
      msg_last_in  = msg_last_ff;
      wr_en        = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         sae_pkg::S_IDLE: begin
            idx_in = '0;
            if (accept) begin
               msg_last_in = req_data.in_last;
               tail_in     = req_data.in_byte;
               post_in     = 1'b0;
               if (!pending_ff) begin
                  if (is_amp && req_data.in_last) begin
                     // ampersand closing the message: '&' then "amp;"
                     post_in  = 1'b1;
                     state_in = sae_pkg::S_TAIL;
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{out_byte: req_data.in_byte, out_last: 1'b1,
                                      out_msg_end: req_data.in_last};
                     pending_in   = is_amp;
                  end
               end else if (is_semi) begin
                  pending_in = 1'b0;
                  state_in   = (count_ff != '0) ? sae_pkg::S_HELD : sae_pkg::S_TAIL;
               end else if (is_brk || req_data.in_last || closes) begin
                  post_in    = is_amp && req_data.in_last;
                  pending_in = is_amp && !req_data.in_last;
                  state_in   = sae_pkg::S_PRE;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + sae_pkg::CNT_W'(1);
               end
            end
         end
         sae_pkg::S_PRE: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{out_byte: sae_pkg::amp_char(idx_ff[1:0]), out_last: 1'b0,
                                out_msg_end: 1'b0};
               if (idx_ff[1:0] == 2'd3) begin
                  idx_in   = '0;
                  state_in = (count_ff != '0) ? sae_pkg::S_HELD : sae_pkg::S_TAIL;
               end else begin
                  idx_in = idx_ff + sae_pkg::IDX_W'(1);
               end
            end
         end
         sae_pkg::S_HELD: begin
            // rd_addr follows idx_in, so rd_data already holds entry idx_ff
            if (can_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{out_byte: rd_data, out_last: 1'b0, out_msg_end: 1'b0};
               if (last_held) begin
                  idx_in   = '0;
                  count_in = '0;
                  state_in = sae_pkg::S_TAIL;
               end else begin
                  idx_in = idx_ff + sae_pkg::IDX_W'(1);
               end
            end
         end
         sae_pkg::S_TAIL: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{out_byte: tail_ff, out_last: !post_ff,
                                out_msg_end: !post_ff && msg_last_ff};
               idx_in       = '0;
               state_in     = post_ff ? sae_pkg::S_POST : sae_pkg::S_IDLE;
            end
         end
         sae_pkg::S_POST: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{out_byte: sae_pkg::amp_char(idx_ff[1:0]),
                                out_last: (idx_ff[1:0] == 2'd3),
                                out_msg_end: (idx_ff[1:0] == 2'd3) && msg_last_ff};
               if (idx_ff[1:0] == 2'd3) begin
                  idx_in   = '0;
                  state_in = sae_pkg::S_IDLE;
               end else begin
                  idx_in = idx_ff + sae_pkg::IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = sae_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sae_pkg::S_IDLE;
         idx_ff       <= '0;
         count_ff     <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tail_ff     <= tail_in;
      post_ff     <= post_in;
      msg_last_ff <= msg_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   sae_ram #(
      .WIDTH (8),
      .DEPTH (sae_pkg::MAX_ENTITY_LEN)
   ) u_held_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff),
      .wr_data (req_data.in_byte),
      .rd_addr (idx_in[sae_pkg::ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> design/sae_checker.sv
// Port-level checks for the stray ampersand escaper, bound to the top level.
// Depends on sae_pkg and stray_ampersand_escaper.
module sae_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input sae_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input sae_pkg::rsp_type rsp_data
);

   // nothing shown straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result item valid after reset");

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

   // a stalled input item holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled input item changed");

   // message end only on the final byte of an item
   a_msg_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.out_msg_end || rsp_data.out_last))
      else $error("msg end without last");

   // no new item taken while an item's results are part way out
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.out_last |-> req_stall)
      else $error("item taken during a multi-byte release");

endmodule

bind stray_ampersand_escaper sae_checker u_sae_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> tb/sv/escaper_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the stray ampersand escaper: predicts the repaired text for
// each accepted item and checks result items in order. Depends on sae_pkg.
package escaper_tb_pkg;

   // Bytes that close a lookahead without a semicolon.
   function automatic logic breaks_lookahead(input logic [7:0] b);
      unique case (b)
         sae_pkg::CH_AMP, sae_pkg::CH_SPACE, sae_pkg::CH_LT, sae_pkg::CH_GT,
         sae_pkg::CH_CR, sae_pkg::CH_LF, sae_pkg::CH_DQUOT, sae_pkg::CH_SQUOT,
         sae_pkg::CH_NUL: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   class escaper_scoreboard;
      logic             lookahead_open;
      logic [7:0]       held_q[$];      // bytes parked since the last ampersand
      logic [7:0]       burst_q[$];     // bytes one item releases
      sae_pkg::rsp_type repaired_q[$];  // result items still to arrive
      int               failures;

      function new();
         lookahead_open = 1'b0;
         failures = 0;
      endfunction

      function void emit_repair();
         burst_q.push_back(sae_pkg::CH_A);
         burst_q.push_back(sae_pkg::CH_M);
         burst_q.push_back(sae_pkg::CH_P);
         burst_q.push_back(sae_pkg::CH_SEMI);
      endfunction

      function void emit_held();
         foreach (held_q[i]) burst_q.push_back(held_q[i]);
         held_q.delete();
      endfunction

      // An ampersand goes out at once; at message end it is repaired on the spot.
      function void open_entity(input logic msg_last);
         burst_q.push_back(sae_pkg::CH_AMP);
         if (msg_last) begin
            emit_repair();
            lookahead_open = 1'b0;
         end else begin
            lookahead_open = 1'b1;
         end
         held_q.delete();
      endfunction

      function void expect_repair(input sae_pkg::req_type it);
         logic [7:0]       b;
         sae_pkg::rsp_type r;
         b = it.in_byte;
         burst_q.delete();
         if (!lookahead_open) begin
            if (b == sae_pkg::CH_AMP) open_entity(it.in_last);
            else burst_q.push_back(b);
         end else if (b == sae_pkg::CH_SEMI) begin
            emit_held();
            burst_q.push_back(b);
            lookahead_open = 1'b0;
         end else if (breaks_lookahead(b)) begin
            emit_repair();
            emit_held();
            if (b == sae_pkg::CH_AMP) begin
               open_entity(it.in_last);
            end else begin
               burst_q.push_back(b);
               lookahead_open = 1'b0;
            end
         end else if (it.in_last || held_q.size() + 1 >= sae_pkg::MAX_ENTITY_LEN) begin
            emit_repair();
            emit_held();
            burst_q.push_back(b);
            lookahead_open = 1'b0;
         end else begin
            held_q.push_back(b);
         end
         foreach (burst_q[i]) begin
            r.out_byte    = burst_q[i];
            r.out_last    = (i == burst_q.size() - 1);
            r.out_msg_end = r.out_last & it.in_last;
            repaired_q.push_back(r);
         end
      endfunction

      function void check_repaired(input sae_pkg::rsp_type got);
         sae_pkg::rsp_type want;
         if (repaired_q.size() == 0) begin
            $error("unexpected result item: out_byte %02h", got.out_byte);
            failures++;
         end else begin
            want = repaired_q.pop_front();
            if (got.out_byte !== want.out_byte) begin
               $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
               failures++;
            end
            if (got.out_last !== want.out_last) begin
               $error("out_last: expected %0b, got %0b", want.out_last, got.out_last);
               failures++;
            end
            if (got.out_msg_end !== want.out_msg_end) begin
               $error("out_msg_end: expected %0b, got %0b", want.out_msg_end,
                      got.out_msg_end);
               failures++;
            end
         end
      endfunction

      function int outstanding();
         return repaired_q.size();
      endfunction
   endclass

endpackage

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top-level testbench of the stray ampersand escaper: clock, reset, item
// drivers, receiver stalls and watchdog. Depends on sae_pkg and escaper_tb_pkg.
module testbench;

   // Longest legitimate stretch without a handshake is the receiver hold-off
   // below; the watchdog allows several times that.
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int QUIET_LIMIT     = 1500;
   // Room for an accept and the longest release of 38 result bytes, with margin.
   localparam int SETTLE_CYCLES   = 80;
   localparam int PHASE_ITEMS     = 140;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   sae_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   sae_pkg::rsp_type rsp_data;

   escaper_tb_pkg::escaper_scoreboard sb;
   int send_idle_pct = 26;
   int recv_idle_pct = 60;
   int hold_cycles   = 0;
   int sent_items    = 0;
   int quiet_cycles  = 0;

   stray_ampersand_escaper u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Receiver: random stalls at the falling edge, or a long hold-off when the
   // stimulus asks for one. The hold is counted down here, cycle by cycle.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // Monitor: every handshake is seen at the rising edge. An input item is
   // noted before the result of the same edge is checked. The watchdog counts
   // edges with no handshake on either side.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.expect_repair(req_data);
         if (rsp_valid && !rsp_stall) sb.check_repaired(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Offers one item from a falling edge and returns at the falling edge after
   // it was taken. Valid stays high into the next item unless the sender idles.
   task automatic send_item(input logic [7:0] b, input logic msg_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{in_byte: b, in_last: msg_last};
      do @(posedge clock); while (req_stall);
      sent_items++;
      @(negedge clock);
   endtask

   // Sender pauses until every expected result item has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.outstanding() != 0);
   endtask

   // Mostly letters, sometimes any byte that neither ends nor breaks an entity.
   function automatic logic [7:0] ordinary_byte();
      logic [7:0] b;
      do begin
         if ($urandom_range(99) < 70) b = 8'(sae_pkg::CH_A + $urandom_range(25));
         else b = 8'($urandom_range(255));
      end while (b == sae_pkg::CH_SEMI || escaper_tb_pkg::breaks_lookahead(b));
      return b;
   endfunction

   function automatic logic [7:0] breaking_byte();
      unique case ($urandom_range(8))
         0: return sae_pkg::CH_AMP;
         1: return sae_pkg::CH_SPACE;
         2: return sae_pkg::CH_LT;
         3: return sae_pkg::CH_GT;
         4: return sae_pkg::CH_CR;
         5: return sae_pkg::CH_LF;
         6: return sae_pkg::CH_DQUOT;
         7: return sae_pkg::CH_SQUOT;
         default: return sae_pkg::CH_NUL;
      endcase
   endfunction

   // Directed items: field extremes and each special case in turn.
   task automatic directed_items();
      send_item(sae_pkg::CH_NUL, 1'b0);   // NUL outside a lookahead passes straight through
      send_item(8'hFF, 1'b0);
      send_item(sae_pkg::CH_AMP, 1'b0);   // well-formed entity
      send_item(sae_pkg::CH_A, 1'b0);
      send_item(sae_pkg::CH_M, 1'b0);
      send_item(sae_pkg::CH_P, 1'b0);
      send_item(sae_pkg::CH_SEMI, 1'b0);
      send_item(sae_pkg::CH_AMP, 1'b0);   // space breaks the lookahead
      send_item(sae_pkg::CH_M, 1'b0);
      send_item(sae_pkg::CH_SPACE, 1'b0);
      send_item(sae_pkg::CH_AMP, 1'b0);   // second ampersand repairs the first, opens anew
      send_item(sae_pkg::CH_P, 1'b0);
      send_item(sae_pkg::CH_AMP, 1'b0);
      send_item(sae_pkg::CH_A, 1'b0);
      send_item(sae_pkg::CH_SEMI, 1'b0);
      send_item(sae_pkg::CH_AMP, 1'b1);   // ampersand as the last byte of a message
      send_item(sae_pkg::CH_AMP, 1'b0);   // message ends inside a lookahead
      send_item(sae_pkg::CH_A, 1'b0);
      send_item(8'h80, 1'b1);
      send_item(sae_pkg::CH_AMP, 1'b0);   // NUL inside a lookahead
      send_item(sae_pkg::CH_NUL, 1'b0);
      send_item(sae_pkg::CH_SEMI, 1'b1);  // stray semicolon closing a message
   endtask

   // One message built from text runs, entities, broken entities, over-long
   // runs and lookaheads left open for the next run or the message end.
   task automatic send_message();
      logic [7:0] text[$];
      int kind;
      int run_len;
      repeat ($urandom_range(1, 5)) begin
         kind = $urandom_range(99);
         if (kind < 30) begin
            repeat ($urandom_range(1, 4))
               text.push_back(($urandom_range(99) < 80) ? ordinary_byte() : breaking_byte());
         end else begin
            text.push_back(sae_pkg::CH_AMP);
            // Mostly short names, now and then right up to the length limit.
            run_len = ($urandom_range(3) == 0) ?
                      $urandom_range(25, sae_pkg::MAX_ENTITY_LEN - 1) :
                      $urandom_range(0, 8);
            if (kind >= 80 && kind < 90)
               run_len = sae_pkg::MAX_ENTITY_LEN + $urandom_range(0, 3);
            repeat (run_len) text.push_back(ordinary_byte());
            if (kind < 60) text.push_back(sae_pkg::CH_SEMI);
            else if (kind < 80) text.push_back(breaking_byte());
         end
      end
      foreach (text[i]) send_item(text[i], i == text.size() - 1);
   endtask

   // Unstructured bytes over the whole range, with the odd message end.
   task automatic send_noise();
      repeat ($urandom_range(1, 12))
         send_item(8'($urandom_range(255)), $urandom_range(19) == 0);
   endtask

   task automatic run_phase(input int sender_pct, input int receiver_pct, input int quota);
      int target;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      target = sent_items + quota;
      while (sent_items < target) begin
         if ($urandom_range(99) < 85) send_message();
         else send_noise();
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      sb = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      directed_items();
      drain_results();
      run_phase(26, 60, PHASE_ITEMS);
      drain_results();
      // Long receiver hold-off while items keep coming: the block fills and
      // stalls its input.
      hold_cycles = HOLD_OFF_CYCLES;
      run_phase(60, 26, PHASE_ITEMS);
      drain_results();
      run_phase(0, 0, PHASE_ITEMS);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (sb.failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
